// ----- hdl/tmcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared types and codes of the text mode console writer: the request and
// response beat layouts, the controller states and the character codes.
// ----------------------------------------------------------------------------
package tmcw_pkg;

   // Request kinds.
   localparam logic REQ_PRINT = 1'b0;
   localparam logic REQ_READ  = 1'b1;

   // Control characters and fill values.
   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [7:0] CHAR_TAB       = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] RESET_ATTR     = 8'h07;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILL_ATTR    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_PAGE = 1'b1;
   localparam int CSR_DATA_W = 8;

   // One request beat.
   typedef struct packed {
      logic       req_type;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_beat_type;

   // One response beat.
   typedef struct packed {
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic [15:0] cursor_address;
      logic [7:0]  cell_char;
      logic [7:0]  cell_attr;
   } rsp_beat_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_FILL
   } state_type;

endpackage

// ----- hdl/text_mode_console_writer_unit.sv -----
// ----------------------------------------------------------------------------
// text_mode_console_writer_unit
// Text console with a character store and an attribute store, a cursor,
// control codes for tab, newline and backspace, scrolling and cell reads.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   req       in         req_valid / req_stall   tmcw_pkg::req_beat_type
//   rsp       out        rsp_valid / rsp_stall   tmcw_pkg::rsp_beat_type
//   csr       in         csr_we                  csr_index, csr_wdata
//
// A print beat is handled in the idle state; a read beat also passes through
// the read state, as the cell stores have a registered read. A print that
// scrolls is followed by the copy and fill states, in which the row copy and
// the bottom row fill go through the store write port one cell a cycle; its
// response is issued at once. After reset a clearing pass writes every cell
// before the first request beat is taken; csr writes are taken throughout.
// A stalled response holds the next request until the output stage frees.
//
module text_mode_console_writer_unit #(
   parameter int COLUMNS    = 80,
   parameter int ROWS       = 25,
   parameter int TAB_STOP   = 8,
   parameter int PAGE_CELLS = 2048
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tmcw_pkg::req_beat_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tmcw_pkg::rsp_beat_type              rsp_data,
   input  logic                                csr_we,
   input  logic [tmcw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tmcw_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CELLS     = COLUMNS * ROWS;
   localparam int CELL_W    = $clog2(CELLS);
   localparam int COL_W     = $clog2(COLUMNS);
   localparam int ROW_W     = $clog2(ROWS);
   localparam int PH_W      = $clog2(TAB_STOP);
   localparam int COLX_W    = COL_W + 1;
   localparam int PHX_W     = PH_W + 1;
   localparam int SUM_W     = ((COLX_W > PHX_W) ? COLX_W : PHX_W) + 1;
   localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

   // Cell stores.
   logic [7:0] char_mem [CELLS];
   logic [7:0] attr_mem [CELLS];

   // Registers.
   tmcw_pkg::state_type    state_ff, state_in;
   logic [CELL_W-1:0]      scan_ff, scan_in;
   logic                   copy_pend_ff, copy_pend_in;
   logic [CELL_W-1:0]      copy_dst_ff;
   logic [COL_W-1:0]       col_ff, col_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [CELL_W-1:0]      lin_ff, lin_in;
   logic [PH_W-1:0]        phase_ff, phase_in;
   logic [7:0]             fill_attr_ff;
   logic [2:0]             page_ff;
   logic [7:0]             scroll_attr_ff;
   logic [7:0]             rd_char_ff;
   logic [7:0]             rd_attr_ff;
   logic                   rd_hit_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   tmcw_pkg::rsp_beat_type rsp_data_ff;

   // Cursor update results for the offered request.
   logic [COL_W-1:0]  col_nx;
   logic [ROW_W-1:0]  row_nx;
   logic [CELL_W-1:0] lin_nx;
   logic [PH_W-1:0]   phase_nx;
   logic              scroll_req;
   logic              print_we;
   logic [CELL_W-1:0] print_addr;
   logic [7:0]        print_char;
   logic [15:0]       cur_addr;
   logic              rd_hit;
   logic [CELL_W-1:0] read_lin;

   // Store port controls.
   logic              accept;
   logic              we_char;
   logic              we_attr;
   logic [CELL_W-1:0] waddr;
   logic [7:0]        wchar;
   logic [7:0]        wattr;
   logic              re;
   logic [CELL_W-1:0] raddr;

   // Cursor movement for a print beat. The linear index and the tab phase
   // follow the column so that no multiply or divide sits on this path.
   always_comb begin
      logic [COLX_W-1:0] col_inc;
      logic [PHX_W-1:0]  tab_dist;
      logic [SUM_W-1:0]  tab_nx;
      logic              nl_scroll;
      logic [ROW_W-1:0]  row_nl;
      logic [CELL_W-1:0] lin_nl;
      logic              take_nl;

      col_inc   = COLX_W'(col_ff) + COLX_W'(1);
      tab_dist  = PHX_W'(TAB_STOP) - PHX_W'(phase_ff);
      tab_nx    = SUM_W'(col_ff) + SUM_W'(tab_dist);
      nl_scroll = (row_ff == ROW_W'(ROWS - 1));
      row_nl    = nl_scroll ? row_ff : row_ff + ROW_W'(1);
      lin_nl    = nl_scroll ? CELL_W'(LAST_BASE)
                            : lin_ff - CELL_W'(col_ff) + CELL_W'(COLUMNS);
      take_nl    = 1'b0;
      col_nx     = col_ff;
      row_nx     = row_ff;
      lin_nx     = lin_ff;
      phase_nx   = phase_ff;
      scroll_req = 1'b0;
      print_we   = 1'b0;
      print_addr = lin_ff;
      print_char = req_data.char_code;

      if (req_data.req_type == tmcw_pkg::REQ_PRINT) begin
         case (req_data.char_code)
            tmcw_pkg::CHAR_TAB: begin
               if (tab_nx >= SUM_W'(COLUMNS)) begin
                  take_nl = 1'b1;
               end else begin
                  col_nx   = COL_W'(tab_nx);
                  lin_nx   = lin_ff + CELL_W'(tab_dist);
                  phase_nx = '0;
               end
            end
            tmcw_pkg::CHAR_NEWLINE: begin
               take_nl = 1'b1;
            end
            tmcw_pkg::CHAR_BACKSPACE: begin
               // Blank the cell to the left; the cursor stays.
               if (col_ff != '0) begin
                  print_we   = 1'b1;
                  print_addr = lin_ff - CELL_W'(1);
                  print_char = tmcw_pkg::CHAR_SPACE;
               end
            end
            default: begin
               print_we = 1'b1;
               if (col_inc == COLX_W'(COLUMNS)) begin
                  take_nl = 1'b1;
               end else begin
                  col_nx   = COL_W'(col_inc);
                  lin_nx   = lin_ff + CELL_W'(1);
                  phase_nx = (phase_ff == PH_W'(TAB_STOP - 1)) ? '0
                                                               : phase_ff + PH_W'(1);
               end
            end
         endcase
      end

      if (take_nl) begin
         col_nx     = '0;
         row_nx     = row_nl;
         lin_nx     = lin_nl;
         phase_nx   = '0;
         scroll_req = nl_scroll;
      end
   end

   // Cursor address and read cell index.
   always_comb begin
      cur_addr = 16'(lin_nx) + 16'(page_ff) * 16'(PAGE_CELLS);
      rd_hit   = (int'(req_data.read_row) < ROWS) && (int'(req_data.read_col) < COLUMNS);
      read_lin = CELL_W'(int'(req_data.read_row) * COLUMNS + int'(req_data.read_col));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tmcw_pkg::ST_CLEAR: begin
            if (scan_ff == CELL_W'(CELLS - 1)) state_in = tmcw_pkg::ST_IDLE;
         end
         tmcw_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.req_type == tmcw_pkg::REQ_READ) begin
                  state_in = tmcw_pkg::ST_READ;
               end else if (scroll_req) begin
                  state_in = tmcw_pkg::ST_COPY;
               end
            end
         end
         tmcw_pkg::ST_READ: begin
            state_in = tmcw_pkg::ST_IDLE;
         end
         tmcw_pkg::ST_COPY: begin
            if (scan_ff == CELL_W'(CELLS - 1)) state_in = tmcw_pkg::ST_FILL;
         end
         tmcw_pkg::ST_FILL: begin
            if (!copy_pend_ff && scan_ff == CELL_W'(CELLS - 1)) state_in = tmcw_pkg::ST_IDLE;
         end
         default: begin
            state_in = tmcw_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs: handshake, store ports and the scan counter.
   always_comb begin
      req_stall    = (state_ff != tmcw_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
      accept       = req_valid && !req_stall;
      we_char      = 1'b0;
      we_attr      = 1'b0;
      waddr        = scan_ff;
      wchar        = tmcw_pkg::CHAR_SPACE;
      wattr        = tmcw_pkg::RESET_ATTR;
      re           = 1'b0;
      raddr        = scan_ff;
      scan_in      = scan_ff;
      copy_pend_in = 1'b0;

      case (state_ff)
         tmcw_pkg::ST_CLEAR: begin
            we_char = 1'b1;
            we_attr = 1'b1;
            scan_in = scan_ff + CELL_W'(1);
         end
         tmcw_pkg::ST_IDLE: begin
            if (accept && req_data.req_type == tmcw_pkg::REQ_READ) begin
               re    = rd_hit;
               raddr = read_lin;
            end
            if (accept && req_data.req_type == tmcw_pkg::REQ_PRINT) begin
               we_char = print_we;
               waddr   = print_addr;
               wchar   = print_char;
               if (scroll_req) scan_in = CELL_W'(COLUMNS);
            end
         end
         tmcw_pkg::ST_READ: begin
            scan_in = scan_ff;
         end
         tmcw_pkg::ST_COPY: begin
            // Read one row further down; the write lands in the next cycle.
            re           = 1'b1;
            copy_pend_in = 1'b1;
            scan_in      = (scan_ff == CELL_W'(CELLS - 1)) ? CELL_W'(LAST_BASE)
                                                           : scan_ff + CELL_W'(1);
            if (copy_pend_ff) begin
               we_char = 1'b1;
               we_attr = 1'b1;
               waddr   = copy_dst_ff;
               wchar   = rd_char_ff;
               wattr   = rd_attr_ff;
            end
         end
         tmcw_pkg::ST_FILL: begin
            we_char = 1'b1;
            we_attr = 1'b1;
            if (copy_pend_ff) begin
               // Drain the last copy before the fill takes the port.
               waddr = copy_dst_ff;
               wchar = rd_char_ff;
               wattr = rd_attr_ff;
            end else begin
               wattr   = scroll_attr_ff;
               scan_in = scan_ff + CELL_W'(1);
            end
         end
         default: begin
            scan_in = scan_ff;
         end
      endcase
   end

   // Cursor and response valid next values.
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      lin_in       = lin_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (accept) begin
         col_in   = col_nx;
         row_in   = row_nx;
         lin_in   = lin_nx;
         phase_in = phase_nx;
         if (req_data.req_type == tmcw_pkg::REQ_PRINT) rsp_valid_in = 1'b1;
      end
      if (state_ff == tmcw_pkg::ST_READ) rsp_valid_in = 1'b1;
   end

   // Cell stores: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (we_char) char_mem[waddr] <= wchar;
      if (we_attr) attr_mem[waddr] <= wattr;
      if (re) begin
         rd_char_ff <= char_mem[raddr];
         rd_attr_ff <= attr_mem[raddr];
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tmcw_pkg::ST_CLEAR;
         scan_ff      <= '0;
         copy_pend_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         lin_ff       <= '0;
         phase_ff     <= '0;
         fill_attr_ff <= tmcw_pkg::RESET_ATTR;
         page_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         copy_pend_ff <= copy_pend_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         lin_ff       <= lin_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               tmcw_pkg::CSR_FILL_ATTR:    fill_attr_ff <= csr_wdata;
               tmcw_pkg::CSR_DISPLAY_PAGE: page_ff      <= csr_wdata[2:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      copy_dst_ff <= scan_ff - CELL_W'(COLUMNS);
      if (accept) begin
         // The fill attribute is held for the whole scroll.
         scroll_attr_ff             <= fill_attr_ff;
         rd_hit_ff                  <= rd_hit;
         rsp_data_ff.cursor_col     <= 7'(col_nx);
         rsp_data_ff.cursor_row     <= 5'(row_nx);
         rsp_data_ff.cursor_address <= cur_addr;
         rsp_data_ff.cell_char      <= '0;
         rsp_data_ff.cell_attr      <= '0;
      end
      if (state_ff == tmcw_pkg::ST_READ) begin
         rsp_data_ff.cell_char <= rd_hit_ff ? rd_char_ff : 8'd0;
         rsp_data_ff.cell_attr <= rd_hit_ff ? rd_attr_ff : 8'd0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The cursor stays on the screen.
   assert property (@(posedge clock) disable iff (reset)
      (int'(col_ff) < COLUMNS) && (int'(row_ff) < ROWS))
      else $error("cursor left the screen");

   // The linear cursor index tracks the row and column.
   assert property (@(posedge clock) disable iff (reset)
      int'(lin_ff) == int'(row_ff) * COLUMNS + int'(col_ff))
      else $error("linear cursor index out of step");

   // A read beat issues its response right after the store access.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tmcw_pkg::ST_READ) |=> rsp_valid_ff)
      else $error("read response missing");

   // No copy write is left pending when new requests are taken.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tmcw_pkg::ST_IDLE) |-> !copy_pend_ff)
      else $error("scroll copy still pending in idle");

endmodule
